@@ design/hdsa_pkg.sv @@
// package for the half-duplex slot arbiter: widths, codes, result word layout
// and the slot admission check
// no dependencies
`default_nettype none

package hdsa_pkg;

	localparam int CAP_W       = 3;
	localparam int PEND_W      = 8;
	localparam int NUM_CLASSES = 4;
	localparam int CLS_W       = 2;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 16;

	localparam logic [PEND_W-1:0] MAX_PENDING       = 8'd255;
	localparam logic [CAP_W-1:0]  CAPACITY_AT_RESET = 3'd3;

	// operation codes carried on the input tuser
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic PRIO_NORMAL = 1'b0;
	localparam logic PRIO_HIGH   = 1'b1;

	// direction codes as they travel in tdata
	localparam logic DIR_SEND = 1'b0;
	localparam logic DIR_RECV = 1'b1;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [4:0]       pad;
		logic             bus_direction_now;
		logic [CAP_W-1:0] slots_in_use_now;
		logic             error_flag;
		logic             queued;
		logic             grant_direction;
		logic             grant_priority;
		logic [CAP_W-1:0] grant_count;
	} result_t;

	typedef logic [PEND_W-1:0] pend_t;

	// a slot is free and the bus is empty or already runs the wanted way
	function automatic logic can_admit(input logic [CAP_W-1:0] slots,
		input logic [CAP_W-1:0] cap, input logic cur_dir, input logic want_dir);
		can_admit = (slots < cap) && ((slots == '0) || (cur_dir == want_dir));
	endfunction

endpackage

`default_nettype wire

@@ design/half_duplex_slot_arbiter.sv @@
// top level of the half-duplex slot arbiter: input register, event logic,
// arbiter state and result register
// depends on hdsa_pkg
//
// channel    | dir | payload
// s_axis     | in  | tuser: operation; tdata: task_priority, task_direction
// m_axis     | out | tdata: grant_count .. bus_direction_now (see port comment)
// cfg        | in  | cfg_wdata: slot limit of the bus, written when cfg_we is high
//
// one event per cycle unless a stalled result holds the pipe: the event logic
// takes the word in the input register, updates the slot count, bus direction and
// pending counters and loads the result register in the same edge
// an accepted input word passes through the input register, then the result register
// a stalled result holds the pipe; s_axis_tready follows m_axis_tready when
// both registers are full
// reset clears the state, empties both registers and sets capacity to three
`default_nettype none

module half_duplex_slot_arbiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] task_priority, [1] task_direction, [7:2] zero
	input  logic [hdsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] operation
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [2:0] grant_count, [3] grant_priority, [4] grant_direction, [5] queued,
	// [6] error_flag, [9:7] slots_in_use_now, [10] bus_direction_now, [15:11] zero
	output logic [hdsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [hdsa_pkg::CAP_W-1:0]       cfg_wdata
);
	import hdsa_pkg::*;

	// input stage
	logic             valid_s1;
	logic             op_s1;
	logic             pri_s1;
	logic             dir_s1;
	logic             advance;

	// arbiter state
	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] slots_q;
	logic             dir_q;
	pend_t            pend_q [NUM_CLASSES];

	// next state
	logic [CAP_W-1:0] slots_d;
	logic             dir_d;
	pend_t            pend_d [NUM_CLASSES];

	// result register
	logic             out_valid_q;
	result_t          res_d;
	result_t          res_q;

	// event decode
	logic [CLS_W-1:0] req_idx;
	pend_t            req_cnt;
	logic             prio_ok;
	logic [CAP_W-1:0] slots_dec;
	logic             wake_any;
	logic             wake_batch;
	logic [CLS_W-1:0] wake_idx;
	logic             wake_dir;
	pend_t            wake_cnt;
	logic [CAP_W-1:0] batch_n;

	// pipe moves when the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1  <= s_axis_tuser;
			pri_s1 <= s_axis_tdata[0];
			dir_s1 <= s_axis_tdata[1];
		end
	end

	// request side lookups
	assign req_idx   = {pri_s1, dir_s1};
	assign req_cnt   = pend_q[req_idx];
	assign prio_ok   = (pri_s1 == PRIO_HIGH) ||
		((pend_q[{PRIO_HIGH, DIR_SEND}] == '0) && (pend_q[{PRIO_HIGH, DIR_RECV}] == '0));
	assign slots_dec = slots_q - 3'd1;

	// wake order: priority same way, priority other way, normal same, normal other
	always_comb begin
		wake_any   = 1'b1;
		wake_batch = 1'b0;
		wake_idx   = {PRIO_HIGH, dir_s1};
		if (pend_q[{PRIO_HIGH, dir_s1}] != '0) begin
			wake_idx = {PRIO_HIGH, dir_s1};
		end else if (pend_q[{PRIO_HIGH, ~dir_s1}] != '0) begin
			wake_idx   = {PRIO_HIGH, ~dir_s1};
			wake_batch = 1'b1;
		end else if (pend_q[{PRIO_NORMAL, dir_s1}] != '0) begin
			wake_idx = {PRIO_NORMAL, dir_s1};
		end else if (pend_q[{PRIO_NORMAL, ~dir_s1}] != '0) begin
			wake_idx   = {PRIO_NORMAL, ~dir_s1};
			wake_batch = 1'b1;
		end else begin
			wake_any = 1'b0;
		end
	end

	assign wake_dir = wake_idx[0];
	assign wake_cnt = pend_q[wake_idx];
	// batch wake fills the empty bus up to capacity
	assign batch_n  = (wake_cnt > {{(PEND_W-CAP_W){1'b0}}, cap_q}) ? cap_q
		: wake_cnt[CAP_W-1:0];

	always_comb begin
		slots_d = slots_q;
		dir_d   = dir_q;
		pend_d  = pend_q;
		res_d   = '0;
		if (op_s1 == OP_REQUEST) begin
			if (can_admit(slots_q, cap_q, dir_q, dir_s1) && prio_ok) begin
				slots_d               = slots_q + 3'd1;
				dir_d                 = dir_s1;
				res_d.grant_count     = 3'd1;
				res_d.grant_priority  = pri_s1;
				res_d.grant_direction = dir_s1;
			end else if (req_cnt >= MAX_PENDING) begin
				// counter full: request dropped
				res_d.error_flag = 1'b1;
			end else begin
				pend_d[req_idx] = req_cnt + 8'd1;
				res_d.queued    = 1'b1;
			end
		end else if (slots_q == '0) begin
			// release on an empty bus is ignored
			res_d.error_flag = 1'b1;
		end else begin
			slots_d = slots_dec;
			if (wake_any) begin
				if (!wake_batch) begin
					if (can_admit(slots_dec, cap_q, dir_q, wake_dir)) begin
						pend_d[wake_idx]  = wake_cnt - 8'd1;
						slots_d           = slots_q;
						dir_d             = wake_dir;
						res_d.grant_count = 3'd1;
					end
				end else if (slots_dec == '0) begin
					pend_d[wake_idx]  = wake_cnt - {{(PEND_W-CAP_W){1'b0}}, batch_n};
					slots_d           = batch_n;
					res_d.grant_count = batch_n;
					if (batch_n != '0) begin
						dir_d = wake_dir;
					end
				end
				if (res_d.grant_count != '0) begin
					res_d.grant_priority  = wake_idx[1];
					res_d.grant_direction = wake_dir;
				end
			end
		end
		res_d.slots_in_use_now  = slots_d;
		res_d.bus_direction_now = dir_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAPACITY_AT_RESET;
			slots_q <= '0;
			dir_q   <= DIR_SEND;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				pend_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (advance) begin
				slots_q <= slots_d;
				dir_q   <= dir_d;
				pend_q  <= pend_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// a release on an empty bus leaves it empty
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (op_s1 == OP_RELEASE) && (slots_q == '0) |=> (slots_q == '0))
		else $error("release on empty bus changed slot count");

	// bus direction only turns when some task is granted
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_d.grant_count == '0) |=> $stable(dir_q))
		else $error("bus direction changed without a grant");

	// a queued request is neither granted nor flagged
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.queued |-> (res_q.grant_count == '0) && !res_q.error_flag)
		else $error("queued result also carries a grant or an error");

	// a result waiting on a stalled sink is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(res_q))
		else $error("stalled result register changed");

endmodule

`default_nettype wire
